// ===== design/crc8r_pkg.sv =====
// Shared types, constants and the CRC-8 byte function for the frame receiver.
// Depends on nothing; the frame tracker, result buffer and top level import it.
`default_nettype none

package crc8r_pkg;

  // CRC-8 settings: polynomial 0x31, initial value 0xFF, MSB first, no final XOR.
  localparam logic [7:0] CRC_POLY   = 8'h31;
  localparam logic [7:0] CRC_INIT   = 8'hFF;
  localparam logic [7:0] CRC_TOPBIT = 8'h80;

  // Byte positions within the six-byte reply.
  typedef logic [2:0] pos_t;
  localparam pos_t POS_FIRST  = 3'd0;
  localparam pos_t POS_CHECK0 = 3'd2;
  localparam pos_t POS_CHECK1 = 3'd5;
  localparam pos_t FRAME_LEN  = 3'd6;

  // One result item.
  typedef struct packed {
    logic [31:0] serial_value;
    logic        crc_mismatch;
  } res_t;

  // Advance the CRC by one byte, unrolled over eight bit steps.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOPBIT) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/crc8r_if.sv =====
// Valid/ready channel interfaces for the frame receiver's byte input and result output.
// Depends on nothing.
`default_nettype none

interface crc8r_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface crc8r_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] serial_value;
  logic        crc_mismatch;

  modport source (output valid, output serial_value, output crc_mismatch, input ready);
  modport sink   (input valid, input serial_value, input crc_mismatch, output ready);
endinterface

`default_nettype wire

// ===== design/crc8r_frame.sv =====
// Frame tracker: byte position, running CRC, serial accumulator and error flag.
// Depends on crc8r_pkg for the CRC function, positions and result type.
`default_nettype none

module crc8r_frame
  import crc8r_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc,
  input  wire logic [7:0] rx_byte,
  input  wire logic       frame_start,
  output      logic       res_valid,
  output      res_t       res
);

  pos_t        pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [31:0] ser_r, ser_nxt;
  logic        err_r, err_nxt;

  pos_t        eff_pos;
  logic [7:0]  base_crc;
  logic [31:0] base_ser;
  logic        base_err;
  logic        restart;

  // A start mark or an out-of-range position begins a fresh frame.
  always_comb begin
    restart  = frame_start || (pos_r >= FRAME_LEN);
    eff_pos  = restart ? POS_FIRST : pos_r;
    base_crc = restart ? CRC_INIT : crc_r;
    base_ser = restart ? 32'd0 : ser_r;
    base_err = restart ? 1'b0 : err_r;
  end

  // Single-pass update of the frame state for one accepted byte.
  always_comb begin
    pos_nxt          = pos_r;
    crc_nxt          = crc_r;
    ser_nxt          = ser_r;
    err_nxt          = err_r;
    res_valid        = 1'b0;
    res.serial_value = base_ser;
    res.crc_mismatch = base_err || (base_crc != rx_byte);
    if (acc) begin
      case (eff_pos)
        POS_CHECK0: begin
          err_nxt = base_err || (base_crc != rx_byte);
          crc_nxt = CRC_INIT;
          ser_nxt = base_ser;
          pos_nxt = POS_CHECK0 + 3'd1;
        end
        POS_CHECK1: begin
          res_valid = 1'b1;
          pos_nxt   = POS_FIRST;
          crc_nxt   = CRC_INIT;
          ser_nxt   = 32'd0;
          err_nxt   = 1'b0;
        end
        default: begin
          // Data bytes: fold into the CRC and shift into the serial number.
          crc_nxt = crc8_byte(base_crc, rx_byte);
          ser_nxt = {base_ser[23:0], rx_byte};
          err_nxt = base_err;
          pos_nxt = eff_pos + 3'd1;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_FIRST;
      crc_r <= CRC_INIT;
      ser_r <= 32'd0;
      err_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      ser_r <= ser_nxt;
      err_r <= err_nxt;
    end
  end

  // The position never leaves the six-byte frame.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n) pos_r < FRAME_LEN)
    else $error("frame position out of range");

  // A result appears only for an accepted byte at the second check position.
  a_res_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (acc && (eff_pos == POS_CHECK1)))
    else $error("result outside the last byte of a frame");

  // After a result the frame restarts with a clean CRC and accumulator.
  a_restart_after_res: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (pos_r == POS_FIRST) && (crc_r == CRC_INIT) && (ser_r == 32'd0) && !err_r)
    else $error("frame not cleared after result");

  // The first check byte reloads the CRC for the second word.
  a_crc_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (eff_pos == POS_CHECK0)) |=> (crc_r == CRC_INIT) && (pos_r == POS_CHECK0 + 3'd1))
    else $error("CRC not reloaded after first check byte");

endmodule

`default_nettype wire

// ===== design/crc8r_outbuf.sv =====
// Two-entry result buffer that decouples the byte input from a stalled result sink.
// Depends on crc8r_pkg for the result type.
`default_nettype none

module crc8r_outbuf
  import crc8r_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire res_t push_data,
  output      logic space,
  output      logic out_valid,
  input  wire logic out_ready,
  output      res_t out_data
);

  res_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign space     = (cnt_r != 2'd2);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // The fill count never exceeds the two entries.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("result buffer overflow");

  // Nothing is written while the buffer is full.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> space)
    else $error("write into full result buffer");

  // Fill count equals the pointer distance.
  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) == (wr_ptr_r != rd_ptr_r))
    else $error("pointers disagree with fill count");

endmodule

`default_nettype wire

// ===== design/crc8_checked_serial_frame_receiver_top.sv =====
// Top level of the CRC-8 checked serial-number frame receiver.
// Depends on crc8r_pkg, crc8r_if, crc8r_frame and crc8r_outbuf.
//
// Usage: bytes of a six-byte sensor reply arrive one per request on in_ch
// (rx_byte, frame_start). Each word is two data bytes and a CRC-8 byte
// (polynomial 0x31, initial 0xFF, MSB first). frame_start on a byte drops any
// partial frame and makes that byte the first of a new one. After the sixth
// byte, one request leaves on out_ch: the four data bytes as a big-endian
// serial_value and crc_mismatch set if either word failed its check.
// Throughput: one byte per cycle while in_ch.ready is high. The CRC over a byte is eight unrolled bit
// steps inside the single update stage of the frame tracker.
// Results are registered in a two-entry result buffer before they leave on
// out_ch; the buffer holds results while the sink stalls, and in_ch.ready
// drops only when both entries are occupied.
// Reset (rst_n low, synchronous) clears the frame position, CRC, accumulator,
// error flag and result buffer.
`default_nettype none

module crc8_checked_serial_frame_receiver_top
  import crc8r_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  crc8r_in_if.sink    in_ch,
  crc8r_out_if.source out_ch
);

  logic acc;
  logic res_valid;
  res_t res;
  logic space;
  res_t out_data;

  assign in_ch.ready = space;
  assign acc         = in_ch.valid && space;

  // Frame state and single-pass byte processing.
  crc8r_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .rx_byte     (in_ch.rx_byte),
    .frame_start (in_ch.frame_start),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result buffering toward the sink.
  crc8r_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.serial_value = out_data.serial_value;
  assign out_ch.crc_mismatch = out_data.crc_mismatch;

endmodule

`default_nettype wire
